// ===== sv/cfd_pkg.sv =====
// Shared types, constants and the FNV byte step for the canonical FNV-1a-64 digest.
`timescale 1ns / 1ps

package cfd_pkg;

    localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
    // The prime is 2^40 + 0x1b3; the step uses this split form.
    localparam int unsigned FNV_PRIME_SH = 40;
    localparam logic [63:0] FNV_PRIME_LO = 64'h00000000000001b3;
    localparam logic [63:0] EXP_MASK     = 64'h7ff0000000000000;
    localparam logic [63:0] NEG_ZERO     = 64'h8000000000000000;

    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned BYTE_CNT_W   = 4;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_WORD   = 2'd1;
    localparam logic [1:0] KIND_DOUBLE = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [BYTE_CNT_W-1:0] NBYTES_NONE = BYTE_CNT_W'(0);
    localparam logic [BYTE_CNT_W-1:0] NBYTES_BYTE = BYTE_CNT_W'(1);
    localparam logic [BYTE_CNT_W-1:0] NBYTES_WORD = BYTE_CNT_W'(8);

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] data_word;
        logic        last_item;
    } in_t;

    typedef struct packed {
        logic [63:0] digest;
        logic        digest_valid;
    } out_t;

    // One classified item waiting for the fold engine.
    typedef struct packed {
        logic [63:0]           data;
        logic [BYTE_CNT_W-1:0] nbytes;
        logic                  poison;
        logic                  last;
    } entry_t;

    function automatic logic [63:0] fnv_fold(input logic [63:0] state, input logic [7:0] b);
        logic [63:0] x;
        x = state ^ {56'd0, b};
        return (x << FNV_PRIME_SH) + (x * FNV_PRIME_LO);
    endfunction

endpackage

// ===== sv/cfd_front.sv =====
// Front end: accepts input beats and classifies them into fold entries.
`timescale 1ns / 1ps

module cfd_front
(
    input  logic            req_valid,
    output logic            req_ready,
    input  cfd_pkg::in_t    req,
    input  logic            queue_full,
    output logic            push,
    output cfd_pkg::entry_t entry
);

    assign req_ready = !queue_full;
    assign push      = req_valid && !queue_full;

    always_comb
    begin
        entry.data   = req.data_word;
        entry.nbytes = cfd_pkg::NBYTES_NONE;
        entry.poison = 1'b0;
        entry.last   = req.last_item;
        unique case (req.req_type)
            cfd_pkg::KIND_BYTE:
            begin
                entry.nbytes = cfd_pkg::NBYTES_BYTE;
            end
            cfd_pkg::KIND_WORD:
            begin
                entry.nbytes = cfd_pkg::NBYTES_WORD;
            end
            cfd_pkg::KIND_DOUBLE:
            begin
                entry.nbytes = cfd_pkg::NBYTES_WORD;
                // NaN or infinity poisons the record
                entry.poison = (req.data_word & cfd_pkg::EXP_MASK) == cfd_pkg::EXP_MASK;
                // fold negative zero as +0
                if (req.data_word == cfd_pkg::NEG_ZERO)
                begin
                    entry.data = 64'd0;
                end
            end
            cfd_pkg::KIND_NONE:
            begin
                entry.nbytes = cfd_pkg::NBYTES_NONE;
            end
            default:
            begin
                entry.nbytes = cfd_pkg::NBYTES_NONE;
            end
        endcase
    end

endmodule

// ===== sv/cfd_queue.sv =====
// Small register queue between the classifier and the fold engine.
`timescale 1ns / 1ps

module cfd_queue
#(
    parameter int unsigned DEPTH = cfd_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cfd_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output cfd_pkg::entry_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    cfd_pkg::entry_t  slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != CNT_W'(0);
    assign head      = slots_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? PTR_W'(0) : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? PTR_W'(0) : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== sv/cfd_back.sv =====
// Fold engine: one FNV byte step per cycle when not stalled, digest output register.
`timescale 1ns / 1ps

module cfd_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            entry_valid,
    input  cfd_pkg::entry_t entry,
    output logic            pop,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output cfd_pkg::out_t   rsp
);

    typedef enum logic
    {
        ST_IDLE,
        ST_BUSY
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [63:0]                    hash_reg;
    logic [63:0]                    hash_next;
    logic                           poison_reg;
    logic                           poison_next;
    logic [63:0]                    data_reg;
    logic [63:0]                    data_next;
    logic [cfd_pkg::BYTE_CNT_W-1:0] count_reg;
    logic [cfd_pkg::BYTE_CNT_W-1:0] count_next;
    logic                           last_reg;
    logic                           last_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    cfd_pkg::out_t                  out_data_reg;
    cfd_pkg::out_t                  out_data_next;

    logic        slot_free;
    logic        finish;
    logic        poison_m;
    logic [63:0] fin_hash;
    logic [7:0]  fold_byte;
    logic [63:0] folded;

    assign slot_free = !out_valid_reg || rsp_ready;
    assign fold_byte = (state_reg == ST_BUSY) ? data_reg[7:0] : entry.data[7:0];
    assign folded    = cfd_pkg::fnv_fold(hash_reg, fold_byte);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        poison_next    = poison_reg;
        data_next      = data_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        finish         = 1'b0;
        poison_m       = poison_reg;
        fin_hash       = hash_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // take a closing entry only when the result slot can hold its digest
                if (entry_valid && (!entry.last || slot_free))
                begin
                    pop         = 1'b1;
                    poison_m    = poison_reg || entry.poison;
                    poison_next = poison_m;
                    if (entry.nbytes == cfd_pkg::NBYTES_NONE)
                    begin
                        finish = entry.last;
                    end
                    else
                    begin
                        hash_next = folded;
                        fin_hash  = folded;
                        if (entry.nbytes == cfd_pkg::NBYTES_BYTE)
                        begin
                            finish = entry.last;
                        end
                        else
                        begin
                            data_next  = {8'd0, entry.data[63:8]};
                            count_next = entry.nbytes - cfd_pkg::BYTE_CNT_W'(1);
                            last_next  = entry.last;
                            state_next = ST_BUSY;
                        end
                    end
                end
            end
            ST_BUSY:
            begin
                hash_next  = folded;
                fin_hash   = folded;
                data_next  = {8'd0, data_reg[63:8]};
                count_next = count_reg - cfd_pkg::BYTE_CNT_W'(1);
                if (count_reg == cfd_pkg::BYTE_CNT_W'(1))
                begin
                    finish     = last_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // emit the record and return to the offset basis
        if (finish)
        begin
            out_valid_next             = 1'b1;
            out_data_next.digest       = poison_m ? 64'd0 : fin_hash;
            out_data_next.digest_valid = !poison_m;
            hash_next                  = cfd_pkg::FNV_BASIS;
            poison_next                = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hash_reg      <= cfd_pkg::FNV_BASIS;
            poison_reg    <= 1'b0;
            data_reg      <= '0;
            count_reg     <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            poison_reg    <= poison_next;
            data_reg      <= data_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

// ===== sv/canonical_fnv1a64_digest.sv =====
// Top level of the canonical FNV-1a-64 digest: classifier, queue and fold engine.
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  cfd_pkg::in_t  (req_type, data_word, last_item)
//  rsp      out        rsp_valid / rsp_ready  cfd_pkg::out_t (digest, digest_valid)
//
// A word or double item folds as eight bytes, low byte first, a raw byte as one, an unused
// kind as none; the engine does one FNV byte step (xor, multiply by the prime) per cycle.
// The classifier fills a QUEUE_DEPTH-entry queue, so req_ready drops only when it is full.
// One digest beat per item marked last; the engine holds a closing item while the result
// register still waits on rsp_ready. Reset is asynchronous and restores the offset basis.
`timescale 1ns / 1ps

module canonical_fnv1a64_digest
#(
    parameter int unsigned QUEUE_DEPTH = cfd_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  cfd_pkg::in_t  req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output cfd_pkg::out_t rsp
);

    logic            push;
    logic            queue_full;
    logic            queue_not_empty;
    logic            pop;
    cfd_pkg::entry_t push_entry;
    cfd_pkg::entry_t head_entry;

    cfd_front u_front
    (
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .queue_full (queue_full),
        .push       (push),
        .entry      (push_entry)
    );

    cfd_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (queue_not_empty),
        .head       (head_entry)
    );

    cfd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (queue_not_empty),
        .entry       (head_entry),
        .pop         (pop),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

endmodule
